### hdl/ddoi_pkg.sv
// Shared types, constants and helper functions of the odometry integrator.
// Used by ddoi_muldiv, ddoi_cordic and diff_drive_odometry_integrator; no dependencies.
package ddoi_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned CORDIC_W         = 34;

  localparam logic [19:0] RADIUS_RESET = 20'd30000;
  localparam logic [23:0] LIN_K        = 24'd921125;
  localparam logic [23:0] HEAD_K       = 24'd174993;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Half of the position divisor, added to the magnitude for rounding.
  localparam logic [63:0] POS_DIV_HALF = 64'd16384000000;

  // The position divisor is 2^21 * 15625. After the shift by 21 the quotient by 15625
  // is estimated with floor(2^37 / 15625) and then corrected by at most one.
  localparam logic [23:0] DIV_ODD = 24'd15625;
  localparam logic [23:0] RECIP_K = 24'd8796093;

  typedef struct packed {
    logic signed [63:0] a;
    logic [23:0]        b;
    logic [4:0]         nbits;
    logic               b_signed;
  } md_req_t;

  // Arctangent table, binary angle with 2^32 equal to two pi.
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Q2.30 to Q1.15 with round half up and saturation.
  function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] t;
    logic signed [CORDIC_W-1:0] s;
    logic signed [15:0]         r;
    t = v + 34'sd16384;
    s = t >>> 15;
    if (s > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (s < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage

### hdl/ddoi_muldiv.sv
// Bit-serial multiplier shared by all products of one tick.
// Depends on ddoi_pkg for the request struct.
module ddoi_muldiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ddoi_pkg::md_req_t   req_i,
  output logic                done_o,
  output logic signed [63:0]  result_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                bsgn_q, bsgn_d;
  logic [4:0]          nbits_q, nbits_d;
  logic [4:0]          cnt_q, cnt_d;
  logic signed [63:0]  acc_q, acc_d;
  logic signed [63:0]  a_q, a_d;
  logic [23:0]         b_q, b_d;

  logic                last;
  logic signed [63:0]  term;

  assign last = (cnt_q == nbits_q - 5'd1);
  assign term = b_q[0] ? a_q : 64'sd0;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    bsgn_d  = bsgn_q;
    nbits_d = nbits_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    a_d     = a_q;
    b_d     = b_q;
    if (start_i) begin
      busy_d  = 1'b1;
      bsgn_d  = req_i.b_signed;
      nbits_d = req_i.nbits;
      cnt_d   = 5'd0;
      acc_d   = 64'sd0;
      a_d     = req_i.a;
      b_d     = req_i.b;
    end else if (busy_q) begin
      // The sign bit of a signed multiplier carries negative weight.
      acc_d = (last && bsgn_q) ? (acc_q - term) : (acc_q + term);
      a_d   = a_q <<< 1;
      b_d   = {1'b0, b_q[23:1]};
      cnt_d = cnt_q + 5'd1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bsgn_q  <= bsgn_d;
    nbits_q <= nbits_d;
    cnt_q   <= cnt_d;
    acc_q   <= acc_d;
    a_q     <= a_d;
    b_q     <= b_d;
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

### hdl/ddoi_cordic.sv
// Iterative rotation-mode CORDIC giving Q1.15 cosine and sine of a 32-bit binary angle.
// Depends on ddoi_pkg for the gain, the arctangent table and the output rounding.
module ddoi_cordic #(
  parameter int unsigned CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        ang_i,
  output logic               done_o,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  localparam int unsigned W = ddoi_pkg::CORDIC_W;
  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  logic                busy_q, done_q, flip_q;
  logic [4:0]          i_q;
  logic signed [W-1:0] x_q, y_q, z_q;

  logic                flip;
  logic [31:0]         ang_r;
  logic signed [W-1:0] xs, ys, at, xf, yf;

  // Angles in the left half plane are turned by pi and the result negated.
  assign flip  = ang_i[31] ^ ang_i[30];
  assign ang_r = {ang_i[31] ^ flip, ang_i[30:0]};
  assign xs    = x_q >>> i_q;
  assign ys    = y_q >>> i_q;
  assign at    = W'(ddoi_pkg::atan_lut(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (i_q == LAST_STEP)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flip_q <= flip;
      i_q    <= 5'd0;
      x_q    <= ddoi_pkg::CORDIC_GAIN;
      y_q    <= '0;
      z_q    <= W'(signed'(ang_r));
    end else if (busy_q) begin
      i_q <= i_q + 5'd1;
      if (!z_q[W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign xf     = flip_q ? -x_q : x_q;
  assign yf     = flip_q ? -y_q : y_q;
  assign cos_o  = ddoi_pkg::to_q15(xf);
  assign sin_o  = ddoi_pkg::to_q15(yf);
  assign done_o = done_q;

endmodule

### hdl/diff_drive_odometry_integrator.sv
// Top level of the differential-drive odometry integrator: sequencer, state and ports.
// Depends on ddoi_pkg, ddoi_muldiv and ddoi_cordic.
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ------------------------------------------
//   input     in_valid_i / in_stall_o    rwheel_spd, lwheel_spd, yaw_rate, elapsed_us,
//                                        imu_valid, motor_valid
//   output    out_valid_o / out_stall_i  pos_x, pos_y, heading, quat_z, quat_w,
//                                        linear_speed, angular_speed
//   config    cfg_we_i                   cfg_wdata_i (wheel radius, micrometers)
//
// The time that a tick which updates the pose takes is set by the shared bit-serial
// multiplier, which runs twelve products one after another (eight for the update and two
// for each position division), and by the two CORDIC passes. A tick with a missing sample
// or zero elapsed time is consumed without starting the sequencer. Reset clears the pose
// and heading and loads the default wheel radius. The input is stalled while a tick is in
// progress; a finished result waits in the output register while the next tick is
// accepted and held only before its own result.
module diff_drive_odometry_integrator #(
  parameter int unsigned CORDIC_STEPS = ddoi_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [19:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [19:0] rwheel_spd_i,
  input  logic signed [19:0] lwheel_spd_i,
  input  logic signed [21:0] yaw_rate_i,
  input  logic [19:0]        elapsed_us_i,
  input  logic               imu_valid_i,
  input  logic               motor_valid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [15:0] heading_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [21:0] linear_speed_o,
  output logic signed [21:0] angular_speed_o
);

  // One-hot sequencer: each state between idle and output runs one operation of a shared unit.
  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000000000000001,
    S_CORD0 = 16'b0000000000000010,
    S_MSR   = 16'b0000000000000100,
    S_MLIN  = 16'b0000000000001000,
    S_MCX   = 16'b0000000000010000,
    S_MVX   = 16'b0000000000100000,
    S_QX    = 16'b0000000001000000,
    S_RX    = 16'b0000000010000000,
    S_MCY   = 16'b0000000100000000,
    S_MVY   = 16'b0000001000000000,
    S_QY    = 16'b0000010000000000,
    S_RY    = 16'b0000100000000000,
    S_MWD   = 16'b0001000000000000,
    S_MHK   = 16'b0010000000000000,
    S_CORD1 = 16'b0100000000000000,
    S_OUT   = 16'b1000000000000000
  } seq_state_e;

  seq_state_e state_q, state_d;

  logic [19:0]        radius_q;
  logic signed [31:0] x_q, x_d;
  logic signed [31:0] y_q, y_d;
  logic [15:0]        yaw_q, yaw_d;

  logic signed [20:0] sum_q;
  logic signed [21:0] w_q;
  logic [19:0]        dt_q;
  logic signed [15:0] c_q, s_q;
  logic signed [21:0] v_q, v_d;
  logic signed [63:0] prod_q, prod_d;
  logic signed [15:0] qz_q, qw_q;
  logic [23:0]        qe_q;

  logic               out_valid_q, out_valid_d;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [15:0]        head_q;
  logic signed [15:0] oqz_q, oqw_q;
  logic signed [21:0] lin_q, ang_q;

  logic               md_start_q, md_start_d;
  logic               cd_start_q, cd_start_d;
  ddoi_pkg::md_req_t  md_req;
  logic               md_done;
  logic signed [63:0] md_res;
  logic [31:0]        cd_ang;
  logic               cd_done;
  logic signed [15:0] cd_cos, cd_sin;

  logic               accept, go;
  logic signed [63:0] lin_t, head_t;
  logic signed [31:0] lin_v;
  logic [63:0]        num_mag;
  logic [35:0]        nrm;
  logic [35:0]        rem_t;
  logic [23:0]        quo;
  logic signed [24:0] dpos;
  logic signed [32:0] x_sum, y_sum;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign go         = imu_valid_i && motor_valid_i && (elapsed_us_i != 20'd0);

  // Forward speed: round the product to Q5.16 and clamp to 22 bits.
  assign lin_t = md_res + 64'sd2147483648;
  assign lin_v = lin_t[63:32];
  always_comb begin
    if (lin_v > 32'sd2097151) begin
      v_d = 22'sh1fffff;
    end else if (lin_v < -32'sd2097152) begin
      v_d = 22'sh200000;
    end else begin
      v_d = lin_v[21:0];
    end
  end

  // Heading step: round by 2^40, keep the low 16 bits for the wrap.
  assign head_t = md_res + 64'sd549755813888;

  // Position step: the magnitude with half the divisor added is divided, so the
  // quotient rounds half away from zero once the sign is restored. The divisor is
  // 2^21 * 15625: the low 21 bits are dropped, the quotient by 15625 is estimated with a
  // reciprocal product shifted by 37, which is low by at most one, and the remainder
  // left after multiplying the estimate back decides the final increment.
  assign num_mag = (prod_q[63] ? 64'(-prod_q) : 64'(prod_q)) + ddoi_pkg::POS_DIV_HALF;
  assign nrm     = num_mag[56:21];
  assign rem_t   = nrm - md_res[35:0];
  assign quo     = qe_q + {23'd0, (rem_t >= 36'(ddoi_pkg::DIV_ODD))};
  assign dpos    = prod_q[63] ? -25'(signed'({1'b0, quo}))
                              : 25'(signed'({1'b0, quo}));
  assign x_sum   = 33'(x_q) + 33'(dpos);
  assign y_sum   = 33'(y_q) + 33'(dpos);

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh07fffffff) begin
      r = 32'sh7fffffff;
    end else if (v < -33'sh080000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Operand selection for the shared multiplier.
  always_comb begin
    md_req          = '0;
    md_req.nbits    = 5'd20;
    md_req.b_signed = 1'b0;
    case (state_q)
      S_MSR: begin
        md_req.a = 64'(sum_q);
        md_req.b = 24'(radius_q);
      end
      S_MLIN: begin
        md_req.a = prod_q;
        md_req.b = ddoi_pkg::LIN_K;
      end
      S_MCX: begin
        md_req.a = 64'(c_q);
        md_req.b = 24'(dt_q);
      end
      S_MCY: begin
        md_req.a = 64'(s_q);
        md_req.b = 24'(dt_q);
      end
      S_MVX, S_MVY: begin
        md_req.a        = prod_q;
        md_req.b        = 24'(unsigned'(v_q));
        md_req.nbits    = 5'd22;
        md_req.b_signed = 1'b1;
      end
      S_QX, S_QY: begin
        md_req.a     = 64'(nrm);
        md_req.b     = ddoi_pkg::RECIP_K;
        md_req.nbits = 5'd24;
      end
      S_RX, S_RY: begin
        md_req.a     = 64'(qe_q);
        md_req.b     = ddoi_pkg::DIV_ODD;
        md_req.nbits = 5'd14;
      end
      S_MWD: begin
        md_req.a = 64'(w_q);
        md_req.b = 24'(dt_q);
      end
      S_MHK: begin
        md_req.a     = prod_q;
        md_req.b     = ddoi_pkg::HEAD_K;
        md_req.nbits = 5'd18;
      end
      default: begin
        md_req.a = prod_q;
      end
    endcase
  end

  // The first pass uses the old heading, the second the new heading times 2^15.
  assign cd_ang = (state_q == S_CORD1) ? {yaw_q[15], yaw_q, 15'd0} : {yaw_q, 16'd0};

  always_comb begin
    state_d     = state_q;
    md_start_d  = 1'b0;
    cd_start_d  = 1'b0;
    prod_d      = prod_q;
    x_d         = x_q;
    y_d         = y_q;
    yaw_d       = yaw_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (accept && go) begin
          state_d    = S_CORD0;
          cd_start_d = 1'b1;
        end
      end
      S_CORD0: begin
        if (cd_done) begin
          state_d    = S_MSR;
          md_start_d = 1'b1;
        end
      end
      S_MSR: begin
        if (md_done) begin
          prod_d     = md_res;
          state_d    = S_MLIN;
          md_start_d = 1'b1;
        end
      end
      S_MLIN: begin
        if (md_done) begin
          state_d    = S_MCX;
          md_start_d = 1'b1;
        end
      end
      S_MCX: begin
        if (md_done) begin
          prod_d     = md_res;
          state_d    = S_MVX;
          md_start_d = 1'b1;
        end
      end
      S_MVX: begin
        if (md_done) begin
          prod_d     = md_res;
          state_d    = S_QX;
          md_start_d = 1'b1;
        end
      end
      S_QX: begin
        if (md_done) begin
          state_d    = S_RX;
          md_start_d = 1'b1;
        end
      end
      S_RX: begin
        if (md_done) begin
          x_d        = sat32(x_sum);
          state_d    = S_MCY;
          md_start_d = 1'b1;
        end
      end
      S_MCY: begin
        if (md_done) begin
          prod_d     = md_res;
          state_d    = S_MVY;
          md_start_d = 1'b1;
        end
      end
      S_MVY: begin
        if (md_done) begin
          prod_d     = md_res;
          state_d    = S_QY;
          md_start_d = 1'b1;
        end
      end
      S_QY: begin
        if (md_done) begin
          state_d    = S_RY;
          md_start_d = 1'b1;
        end
      end
      S_RY: begin
        if (md_done) begin
          y_d        = sat32(y_sum);
          state_d    = S_MWD;
          md_start_d = 1'b1;
        end
      end
      S_MWD: begin
        if (md_done) begin
          prod_d     = md_res;
          state_d    = S_MHK;
          md_start_d = 1'b1;
        end
      end
      S_MHK: begin
        if (md_done) begin
          yaw_d      = yaw_q + head_t[55:40];
          state_d    = S_CORD1;
          cd_start_d = 1'b1;
        end
      end
      S_CORD1: begin
        if (cd_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // The result register must be free before the new pose is loaded.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= ddoi_pkg::RADIUS_RESET;
      x_q         <= '0;
      y_q         <= '0;
      yaw_q       <= '0;
      out_valid_q <= 1'b0;
      md_start_q  <= 1'b0;
      cd_start_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      x_q         <= x_d;
      y_q         <= y_d;
      yaw_q       <= yaw_d;
      out_valid_q <= out_valid_d;
      md_start_q  <= md_start_d;
      cd_start_q  <= cd_start_d;
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (accept) begin
      sum_q <= 21'(rwheel_spd_i) + 21'(lwheel_spd_i);
      w_q   <= yaw_rate_i;
      dt_q  <= elapsed_us_i;
    end
    if ((state_q == S_CORD0) && cd_done) begin
      c_q <= cd_cos;
      s_q <= cd_sin;
    end
    if ((state_q == S_MLIN) && md_done) begin
      v_q <= v_d;
    end
    // Quotient estimate: the reciprocal product shifted right by 37.
    if (((state_q == S_QX) || (state_q == S_QY)) && md_done) begin
      qe_q <= md_res[60:37];
    end
    if ((state_q == S_CORD1) && cd_done) begin
      qw_q <= cd_cos;
      qz_q <= cd_sin;
    end
    if ((state_q == S_OUT) && (!out_valid_q || !out_stall_i)) begin
      pos_x_q <= x_q;
      pos_y_q <= y_q;
      head_q  <= yaw_q;
      oqz_q   <= qz_q;
      oqw_q   <= qw_q;
      lin_q   <= v_q;
      ang_q   <= w_q;
    end
  end

  ddoi_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start_q),
    .req_i    (md_req),
    .done_o   (md_done),
    .result_o (md_res)
  );

  ddoi_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start_q),
    .ang_i   (cd_ang),
    .done_o  (cd_done),
    .cos_o   (cd_cos),
    .sin_o   (cd_sin)
  );

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = pos_x_q;
  assign pos_y_o         = pos_y_q;
  assign heading_o       = head_q;
  assign quat_z_o        = oqz_q;
  assign quat_w_o        = oqw_q;
  assign linear_speed_o  = lin_q;
  assign angular_speed_o = ang_q;

endmodule
